[hdl/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants for the MIPS subset executor
// Action and status codes, register file geometry and the data window base.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned REG_COUNT            = 32;
  localparam int unsigned REG_AW               = 5;
  localparam int unsigned DEFAULT_WINDOW_WORDS = 5;

  localparam logic [31:0]       WINDOW_BASE    = 32'h2000_0000;
  localparam logic [31:0]       RESET_START_PC = 32'h0040_0000;
  localparam logic [REG_AW-1:0] LINK_REG       = 5'd31;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_OR   = 4'd2,
    ACT_AND  = 4'd3,
    ACT_NOR  = 4'd4,
    ACT_ADDI = 4'd5,
    ACT_SLL  = 4'd6,
    ACT_SRL  = 4'd7,
    ACT_BEQ  = 4'd8,
    ACT_BNE  = 4'd9,
    ACT_LW   = 4'd10,
    ACT_SW   = 4'd11,
    ACT_J    = 4'd12,
    ACT_JAL  = 4'd13,
    ACT_JR   = 4'd14,
    ACT_UNK  = 4'd15
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NEG_SHIFT = 3'd1,
    ST_MISALIGN  = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  // Result of one instruction as it leaves the execute stage.
  typedef struct packed {
    status_t           status;
    logic [31:0]       pc_after;
    logic              rw;
    logic [REG_AW-1:0] idx;
    logic [31:0]       val;
    logic              is_load;
    logic              mw;
    logic [2:0]        slot;
    logic              br;
  } result_t;

endpackage

[hdl/mips_subset_executor.sv]
// An accepted instruction is registered into stage 1, then its result into stage 2 for output.
// Throughput: one instruction per cycle while out_ready holds, including back-to-back dependent ones.
// The two-read-port register file and the window memory set that rate.
// Reset (synchronous, rst high) clears the pipeline, loads PC with 0x00400000,
// then sweeps the data window to zero, word by word, before raising in_ready.
// Writes to start_pc through cfg_wen are taken at any time and reload the PC.
// ----------------------------------------------------------------------------
// mips_subset_executor: single-issue execute engine for a MIPS32 subset
// Register file and data window live in synchronous memories; stage 1 reads
// operands and executes, stage 2 holds the result and commits register writes.
// ----------------------------------------------------------------------------
module mips_subset_executor #(
  parameter int unsigned WINDOW_WORDS = mse_pkg::DEFAULT_WINDOW_WORDS
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_wen,
  input  logic [31:0]                cfg_wdata,
  // instruction channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [3:0]                 action,
  input  logic [mse_pkg::REG_AW-1:0] first_reg,
  input  logic [mse_pkg::REG_AW-1:0] second_reg,
  input  logic [mse_pkg::REG_AW-1:0] third_reg,
  input  logic signed [15:0]         immediate,
  input  logic [25:0]                jump_target,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic [31:0]                pc_after,
  output logic                       reg_write,
  output logic [mse_pkg::REG_AW-1:0] reg_index,
  output logic [31:0]                reg_value,
  output logic                       mem_write,
  output logic [2:0]                 mem_slot,
  output logic                       branch_taken
);

  localparam int unsigned RAW   = mse_pkg::REG_AW;
  localparam int unsigned WIN_AW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
  localparam int unsigned CLR_W  = $clog2(WINDOW_WORDS + 1);

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  logic                s1_valid;
  logic                s2_valid;
  logic                s1_adv;
  logic                in_take;
  logic                s2_take;
  logic [CLR_W-1:0]    clr_cnt;
  logic                clear_done;

  assign clear_done = (clr_cnt == CLR_W'(WINDOW_WORDS));
  assign s2_take    = s2_valid && out_ready;
  // Stage 1 moves on when stage 2 is empty or is handing its result over.
  assign s1_adv     = s1_valid && (!s2_valid || out_ready);
  assign in_ready   = clear_done && (!s1_valid || s1_adv);
  assign in_take    = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Stage 1 instruction registers
  // --------------------------------------------------------------------------
  mse_pkg::action_t    s1_action;
  logic [RAW-1:0]      s1_r1;
  logic [RAW-1:0]      s1_ra;   // address read on port A
  logic [RAW-1:0]      s1_rb;   // address read on port B
  logic [15:0]         s1_imm;
  logic [25:0]         s1_tgt;

  // Port B serves the second ALU source for register-register ops and the
  // first_reg operand (compare, store data, jr target) for everything else.
  logic [RAW-1:0]      rb_addr;
  logic                is_rtype;

  always_comb begin
    case (mse_pkg::action_t'(action)) inside
      mse_pkg::ACT_ADD, mse_pkg::ACT_SUB, mse_pkg::ACT_OR,
      mse_pkg::ACT_AND, mse_pkg::ACT_NOR: is_rtype = 1'b1;
      default:                            is_rtype = 1'b0;
    endcase
  end

  assign rb_addr = is_rtype ? third_reg : first_reg;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action <= mse_pkg::action_t'(action);
      s1_r1     <= first_reg;
      s1_ra     <= second_reg;
      s1_rb     <= rb_addr;
      s1_imm    <= immediate;
      s1_tgt    <= jump_target;
    end
  end

  // --------------------------------------------------------------------------
  // Register file: one write port, two registered read ports
  // --------------------------------------------------------------------------
  logic [31:0]             rf_mem [mse_pkg::REG_COUNT];
  logic [31:0]             rf_rd_a;
  logic [31:0]             rf_rd_b;
  logic [mse_pkg::REG_COUNT-1:0] rf_ok;   // entry written since reset
  logic                    rf_we;
  logic [RAW-1:0]          rf_waddr;
  logic [31:0]             rf_wdata;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (in_take) begin
      rf_rd_a <= rf_mem[second_reg];
      rf_rd_b <= rf_mem[rb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_ok <= '0;
    end else if (rf_we) begin
      rf_ok[rf_waddr] <= 1'b1;
    end
  end

  // Last committed write; covers a read issued on the same edge as the write.
  logic                wr_valid;
  logic [RAW-1:0]      wr_idx;
  logic [31:0]         wr_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (rf_we) begin
      wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      wr_idx <= rf_waddr;
      wr_val <= rf_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 result register
  // --------------------------------------------------------------------------
  mse_pkg::result_t    s2;
  mse_pkg::result_t    res;
  logic [31:0]         win_rdata;
  logic [31:0]         s2_wval;

  // A load picks its value from the window read port, which lands with s2.
  assign s2_wval  = s2.is_load ? win_rdata : s2.val;

  assign rf_we    = s2_take && s2.rw;
  assign rf_waddr = s2.idx;
  assign rf_wdata = s2_wval;

  // --------------------------------------------------------------------------
  // Operand forwarding: stage 2 is newest, then the last write, then memory
  // --------------------------------------------------------------------------
  logic [31:0]         op_a;
  logic [31:0]         op_b;

  always_comb begin
    if (s2_valid && s2.rw && (s2.idx == s1_ra)) begin
      op_a = s2_wval;
    end else if (wr_valid && (wr_idx == s1_ra)) begin
      op_a = wr_val;
    end else if (rf_ok[s1_ra]) begin
      op_a = rf_rd_a;
    end else begin
      op_a = '0;
    end
  end

  always_comb begin
    if (s2_valid && s2.rw && (s2.idx == s1_rb)) begin
      op_b = s2_wval;
    end else if (wr_valid && (wr_idx == s1_rb)) begin
      op_b = wr_val;
    end else if (rf_ok[s1_rb]) begin
      op_b = rf_rd_b;
    end else begin
      op_b = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Execute
  // --------------------------------------------------------------------------
  logic [31:0]         pc;
  logic [31:0]         pc_plus4;
  logic [31:0]         pc_next;
  logic [31:0]         imm32;
  logic [31:0]         win_diff;
  logic                win_hit;
  logic [WIN_AW-1:0]   win_idx;

  assign pc_plus4 = pc + 32'd4;
  assign imm32    = {{16{s1_imm[15]}}, s1_imm};
  assign win_diff = op_a + imm32 - mse_pkg::WINDOW_BASE;
  assign win_hit  = (win_diff[1:0] == 2'b00) && (win_diff[31:2] < 30'(WINDOW_WORDS));
  assign win_idx  = win_diff[2 +: WIN_AW];

  always_comb begin
    res          = '0;
    res.status   = mse_pkg::ST_OK;
    pc_next      = pc_plus4;
    unique case (s1_action) inside
      mse_pkg::ACT_ADD: begin
        res.rw = 1'b1; res.idx = s1_r1; res.val = op_a + op_b;
      end
      mse_pkg::ACT_SUB: begin
        res.rw = 1'b1; res.idx = s1_r1; res.val = op_a - op_b;
      end
      mse_pkg::ACT_OR: begin
        res.rw = 1'b1; res.idx = s1_r1; res.val = op_a | op_b;
      end
      mse_pkg::ACT_AND: begin
        res.rw = 1'b1; res.idx = s1_r1; res.val = op_a & op_b;
      end
      mse_pkg::ACT_NOR: begin
        res.rw = 1'b1; res.idx = s1_r1; res.val = ~(op_a | op_b);
      end
      mse_pkg::ACT_ADDI: begin
        res.rw = 1'b1; res.idx = s1_r1; res.val = op_a + imm32;
      end
      mse_pkg::ACT_SLL, mse_pkg::ACT_SRL: begin
        if (s1_imm[15]) begin
          // negative amount: no write, PC holds
          res.status = mse_pkg::ST_NEG_SHIFT;
          pc_next    = pc;
        end else begin
          res.rw  = 1'b1;
          res.idx = s1_r1;
          if (|s1_imm[14:5]) begin
            res.val = '0;
          end else if (s1_action == mse_pkg::ACT_SLL) begin
            res.val = op_a << s1_imm[4:0];
          end else begin
            res.val = op_a >> s1_imm[4:0];
          end
        end
      end
      mse_pkg::ACT_BEQ, mse_pkg::ACT_BNE: begin
        if ((s1_action == mse_pkg::ACT_BEQ) == (op_a == op_b)) begin
          res.br  = 1'b1;
          pc_next = pc_plus4 + {imm32[29:0], 2'b00};
        end
      end
      mse_pkg::ACT_LW, mse_pkg::ACT_SW: begin
        if (s1_imm[1:0] != 2'b00) begin
          res.status = mse_pkg::ST_MISALIGN;
        end else if (!win_hit) begin
          res.status = mse_pkg::ST_OUTSIDE;
        end else begin
          res.slot = win_diff[4:2];
          if (s1_action == mse_pkg::ACT_LW) begin
            res.rw      = 1'b1;
            res.idx     = s1_r1;
            res.is_load = 1'b1;
          end else begin
            res.mw = 1'b1;
          end
        end
      end
      mse_pkg::ACT_J, mse_pkg::ACT_JAL: begin
        res.br  = 1'b1;
        pc_next = {pc_plus4[31:28], s1_tgt, 2'b00};
        if (s1_action == mse_pkg::ACT_JAL) begin
          res.rw  = 1'b1;
          res.idx = mse_pkg::LINK_REG;
          res.val = pc_plus4;
        end
      end
      mse_pkg::ACT_JR: begin
        res.br  = 1'b1;
        pc_next = op_b;
      end
      default: begin
        res.status = mse_pkg::ST_UNKNOWN;
        pc_next    = pc;
      end
    endcase
    res.pc_after = pc_next;
  end

  // Program counter: loaded by configuration, advanced as stage 1 retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mse_pkg::RESET_START_PC;
    end else if (cfg_wen) begin
      pc <= cfg_wdata;
    end else if (s1_adv) begin
      pc <= pc_next;
    end
  end

  // --------------------------------------------------------------------------
  // Data window memory; store writes and load reads both issue as stage 1
  // retires, so a load always sees every earlier store.
  // --------------------------------------------------------------------------
  logic [31:0]         win_mem [WINDOW_WORDS];
  logic                win_st;
  logic                win_ld;

  assign win_st = s1_adv && res.mw;
  assign win_ld = s1_adv && res.is_load;

  always_ff @(posedge clk) begin
    if (!clear_done) begin
      win_mem[clr_cnt[WIN_AW-1:0]] <= '0;
    end else if (win_st) begin
      win_mem[win_idx] <= op_b;
    end
    if (win_ld) begin
      win_rdata <= win_mem[win_idx];
    end
  end

  // Sweep the window to zero after reset, one word per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clear_done) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline valids and stage 2 payload
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_take) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2 <= res;
    end
  end

  // --------------------------------------------------------------------------
  // Result ports
  // --------------------------------------------------------------------------
  assign out_valid    = s2_valid;
  assign status       = s2.status;
  assign pc_after     = s2.pc_after;
  assign reg_write    = s2.rw;
  assign reg_index    = s2.idx;
  assign reg_value    = s2_wval;
  assign mem_write    = s2.mw;
  assign mem_slot     = s2.slot;
  assign branch_taken = s2.br;

endmodule

[hdl/mse_checker.sv]
// ----------------------------------------------------------------------------
// mse_checker: port-level checks for the MIPS subset executor
// Result field consistency and output hold under backpressure.
// ----------------------------------------------------------------------------
module mse_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 status,
  input logic [31:0]                pc_after,
  input logic                       reg_write,
  input logic [mse_pkg::REG_AW-1:0] reg_index,
  input logic [31:0]                reg_value,
  input logic                       mem_write,
  input logic [2:0]                 mem_slot,
  input logic                       branch_taken
);

  // No register written means zero index and value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_write |-> (reg_index == '0) && (reg_value == '0))
    else $error("reg_index/reg_value nonzero without reg_write");

  // A store never comes with a register write or an error status.
  a_store_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_write |-> !reg_write && (status == mse_pkg::ST_OK))
    else $error("store result carries a register write or error");

  // Failed or unknown instructions change no state and take no branch.
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != mse_pkg::ST_OK) |->
      !reg_write && !mem_write && !branch_taken && (mem_slot == 3'd0))
    else $error("error status with side effects");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pc_after) && $stable(status))
    else $error("result changed while stalled");

endmodule

bind mips_subset_executor mse_checker u_mse_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .pc_after     (pc_after),
  .reg_write    (reg_write),
  .reg_index    (reg_index),
  .reg_value    (reg_value),
  .mem_write    (mem_write),
  .mem_slot     (mem_slot),
  .branch_taken (branch_taken)
);

[tb/tb_mips_subset_executor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mips_subset_executor: self-checking bench for the MIPS subset executor
// Feeds decoded instructions over valid/ready with random gaps and result
// back-pressure. A scoreboard mirrors the register file, PC and data window,
// predicts each result and compares it field by field on arrival.
// ----------------------------------------------------------------------------
module tb_mips_subset_executor;

  localparam int unsigned WIN_WORDS   = mse_pkg::DEFAULT_WINDOW_WORDS;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned BURST_ITEMS = 250;

  // One decoded instruction as it crosses the input channel.
  typedef struct {
    mse_pkg::action_t           action;
    logic [mse_pkg::REG_AW-1:0] first_reg;
    logic [mse_pkg::REG_AW-1:0] second_reg;
    logic [mse_pkg::REG_AW-1:0] third_reg;
    logic [15:0]                immediate;
    logic [25:0]                jump_target;
  } instr_t;

  // Architectural effect of one instruction as seen on the result channel.
  typedef struct {
    mse_pkg::status_t           status;
    logic [31:0]                pc_after;
    logic                       reg_write;
    logic [mse_pkg::REG_AW-1:0] reg_index;
    logic [31:0]                reg_value;
    logic                       mem_write;
    logic [2:0]                 mem_slot;
    logic                       branch_taken;
  } outcome_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow machine state plus the queue of predicted outcomes.
  // --------------------------------------------------------------------------
  class exec_scoreboard;
    logic [31:0] gpr [mse_pkg::REG_COUNT];
    logic [31:0] window [WIN_WORDS];
    logic [31:0] pc;
    outcome_t    pending_outcomes [$];
    int unsigned fail_count;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (window[i]) window[i] = '0;
      pc         = mse_pkg::RESET_START_PC;
      fail_count = 0;
    endfunction

    // A start_pc write reloads the PC; registers and window keep their contents.
    function void load_start_pc(logic [31:0] value);
      pc = value;
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
    endtask

    // Execute one instruction on the shadow state and return its outcome.
    function outcome_t execute(instr_t t);
      outcome_t    o;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] imm;
      logic [31:0] nxt;
      logic [31:0] diff;
      logic        eq;
      o.status       = mse_pkg::ST_OK;
      o.reg_write    = 1'b0;
      o.reg_index    = '0;
      o.reg_value    = '0;
      o.mem_write    = 1'b0;
      o.mem_slot     = '0;
      o.branch_taken = 1'b0;
      a   = gpr[t.second_reg];
      b   = gpr[t.third_reg];
      imm = {{16{t.immediate[15]}}, t.immediate};
      nxt = pc + 32'd4;
      case (t.action)
        mse_pkg::ACT_ADD, mse_pkg::ACT_SUB, mse_pkg::ACT_OR, mse_pkg::ACT_AND,
        mse_pkg::ACT_NOR, mse_pkg::ACT_ADDI: begin
          o.reg_write = 1'b1;
          o.reg_index = t.first_reg;
          case (t.action)
            mse_pkg::ACT_ADD: o.reg_value = a + b;
            mse_pkg::ACT_SUB: o.reg_value = a - b;
            mse_pkg::ACT_OR:  o.reg_value = a | b;
            mse_pkg::ACT_AND: o.reg_value = a & b;
            mse_pkg::ACT_NOR: o.reg_value = ~(a | b);
            default:          o.reg_value = a + imm;
          endcase
        end
        mse_pkg::ACT_SLL, mse_pkg::ACT_SRL: begin
          if (imm[31]) begin
            // negative amount: no write and the PC holds
            o.status = mse_pkg::ST_NEG_SHIFT;
            nxt      = pc;
          end else begin
            o.reg_write = 1'b1;
            o.reg_index = t.first_reg;
            if (imm > 32'd31) o.reg_value = '0;
            else if (t.action == mse_pkg::ACT_SLL) o.reg_value = a << imm[4:0];
            else o.reg_value = a >> imm[4:0];
          end
        end
        mse_pkg::ACT_BEQ, mse_pkg::ACT_BNE: begin
          eq = (gpr[t.first_reg] == a);
          if ((t.action == mse_pkg::ACT_BEQ) == eq) begin
            o.branch_taken = 1'b1;
            nxt = nxt + (imm << 2);
          end
        end
        mse_pkg::ACT_LW, mse_pkg::ACT_SW: begin
          if (imm[1:0] != 2'b00) begin
            o.status = mse_pkg::ST_MISALIGN;
          end else begin
            diff = a + imm - mse_pkg::WINDOW_BASE;
            if (diff[1:0] != 2'b00 || (diff >> 2) >= WIN_WORDS) begin
              o.status = mse_pkg::ST_OUTSIDE;
            end else begin
              o.mem_slot = diff[4:2];
              if (t.action == mse_pkg::ACT_LW) begin
                o.reg_write = 1'b1;
                o.reg_index = t.first_reg;
                o.reg_value = window[diff >> 2];
              end else begin
                o.mem_write = 1'b1;
                window[diff >> 2] = gpr[t.first_reg];
              end
            end
          end
        end
        mse_pkg::ACT_J, mse_pkg::ACT_JAL: begin
          if (t.action == mse_pkg::ACT_JAL) begin
            o.reg_write = 1'b1;
            o.reg_index = mse_pkg::LINK_REG;
            o.reg_value = nxt;
          end
          o.branch_taken = 1'b1;
          nxt = {nxt[31:28], t.jump_target, 2'b00};
        end
        mse_pkg::ACT_JR: begin
          o.branch_taken = 1'b1;
          nxt = gpr[t.first_reg];
        end
        default: begin
          o.status = mse_pkg::ST_UNKNOWN;
          nxt      = pc;
        end
      endcase
      if (o.reg_write) gpr[o.reg_index] = o.reg_value;
      pc         = nxt;
      o.pc_after = pc;
      return o;
    endfunction

    function void note_instruction(instr_t t);
      pending_outcomes.push_back(execute(t));
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report("result with no instruction outstanding");
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("status", 32'(got.status), 32'(want.status));
      compare_field("pc_after", got.pc_after, want.pc_after);
      compare_field("reg_write", 32'(got.reg_write), 32'(want.reg_write));
      compare_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
      compare_field("reg_value", got.reg_value, want.reg_value);
      compare_field("mem_write", 32'(got.mem_write), 32'(want.mem_write));
      compare_field("mem_slot", 32'(got.mem_slot), 32'(want.mem_slot));
      compare_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wen;
  logic [31:0]                cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [3:0]                 action;
  logic [mse_pkg::REG_AW-1:0] first_reg;
  logic [mse_pkg::REG_AW-1:0] second_reg;
  logic [mse_pkg::REG_AW-1:0] third_reg;
  logic [15:0]                immediate;
  logic [25:0]                jump_target;
  logic                       out_valid;
  logic                       out_ready;
  logic [2:0]                 status;
  logic [31:0]                pc_after;
  logic                       reg_write;
  logic [mse_pkg::REG_AW-1:0] reg_index;
  logic [31:0]                reg_value;
  logic                       mem_write;
  logic [2:0]                 mem_slot;
  logic                       branch_taken;

  exec_scoreboard sb;
  bit             steady = 1'b0;     // set: no idling on either side
  int unsigned    quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mips_subset_executor dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .first_reg    (first_reg),
    .second_reg   (second_reg),
    .third_reg    (third_reg),
    .immediate    (immediate),
    .jump_target  (jump_target),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .pc_after     (pc_after),
    .reg_write    (reg_write),
    .reg_index    (reg_index),
    .reg_value    (reg_value),
    .mem_write    (mem_write),
    .mem_slot     (mem_slot),
    .branch_taken (branch_taken)
  );

  // Stall the result channel with a probability of about 31 percent unless running steady.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 31);
  end

  // --------------------------------------------------------------------------
  // Monitor: check the finished transaction first, then predict the new one,
  // so a result can never be matched against an instruction taken this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    outcome_t seen;
    instr_t   taken;
    if (!rst && out_valid && out_ready) begin
      seen.status       = mse_pkg::status_t'(status);
      seen.pc_after     = pc_after;
      seen.reg_write    = reg_write;
      seen.reg_index    = reg_index;
      seen.reg_value    = reg_value;
      seen.mem_write    = mem_write;
      seen.mem_slot     = mem_slot;
      seen.branch_taken = branch_taken;
      sb.check_result(seen);
    end
    if (!rst && in_valid && in_ready) begin
      taken.action      = mse_pkg::action_t'(action);
      taken.first_reg   = first_reg;
      taken.second_reg  = second_reg;
      taken.third_reg   = third_reg;
      taken.immediate   = immediate;
      taken.jump_target = jump_target;
      sb.note_instruction(taken);
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic instr_t mk(mse_pkg::action_t op, int r1, int r2, int r3, int imm,
                                int tgt = 0);
    instr_t t;
    t.action      = op;
    t.first_reg   = mse_pkg::REG_AW'(r1);
    t.second_reg  = mse_pkg::REG_AW'(r2);
    t.third_reg   = mse_pkg::REG_AW'(r3);
    t.immediate   = 16'(imm);
    t.jump_target = 26'(tgt);
    return t;
  endfunction

  function automatic int rand_reg();
    return int'($urandom_range(mse_pkg::REG_COUNT - 1));
  endfunction

  function automatic int rand_imm();
    return int'($urandom_range(16'hFFFF));
  endfunction

  function automatic int rand_tgt();
    return int'($urandom_range((1 << 26) - 1));
  endfunction

  // Byte offset around the window: mostly aligned, spilling a word or two
  // past either end, sometimes misaligned.
  function automatic int mem_offset();
    int off;
    off = (int'($urandom_range(8)) - 2) * 4;
    if ($urandom_range(99) < 20) off += int'($urandom_range(3, 1));
    return off;
  endfunction

  // Present one instruction, optionally after a random gap, and hold it
  // until the DUT takes it.
  task automatic send(instr_t t);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    action      <= t.action;
    first_reg   <= t.first_reg;
    second_reg  <= t.second_reg;
    third_reg   <= t.third_reg;
    immediate   <= t.immediate;
    jump_target <= t.jump_target;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted outcome has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.load_start_pc(value);
  endtask

  task automatic run_directed();
    // r0 is an ordinary register; load the immediate extremes through it
    send(mk(mse_pkg::ACT_ADDI, 0, 0, 0, 32767));
    send(mk(mse_pkg::ACT_ADDI, 1, 0, 0, -32768));
    send(mk(mse_pkg::ACT_ADD, 3, 1, 0, 0));
    // subtrahend register doubles as the destination
    send(mk(mse_pkg::ACT_SUB, 3, 1, 3, 0));
    send(mk(mse_pkg::ACT_OR, 4, 1, 0, 0));
    send(mk(mse_pkg::ACT_AND, 5, 1, 0, 0));
    send(mk(mse_pkg::ACT_NOR, 6, 7, 7, 0));
    send(mk(mse_pkg::ACT_SLL, 8, 6, 0, 31));
    send(mk(mse_pkg::ACT_SLL, 9, 6, 0, 32));      // amount above 31 clears
    send(mk(mse_pkg::ACT_SRL, 9, 6, 0, -1));      // negative amount: PC holds
    // build the window base in r10
    send(mk(mse_pkg::ACT_SUB, 10, 6, 6, 0));
    send(mk(mse_pkg::ACT_ADDI, 10, 10, 0, 16'h2000));
    send(mk(mse_pkg::ACT_SLL, 10, 10, 0, 16));
    send(mk(mse_pkg::ACT_SW, 6, 10, 0, 4 * (WIN_WORDS - 1)));
    send(mk(mse_pkg::ACT_LW, 11, 10, 0, 4 * (WIN_WORDS - 1)));
    send(mk(mse_pkg::ACT_LW, 12, 10, 0, 4 * WIN_WORDS));   // one word past the end
    send(mk(mse_pkg::ACT_SW, 12, 10, 0, -4));               // one word below
    send(mk(mse_pkg::ACT_LW, 12, 10, 0, 2));                // misaligned offset
    send(mk(mse_pkg::ACT_BEQ, 0, 0, 0, -32768));
    send(mk(mse_pkg::ACT_BNE, 1, 0, 0, 32767));
    send(mk(mse_pkg::ACT_BEQ, 1, 0, 0, 1));                 // not taken
    send(mk(mse_pkg::ACT_J, 0, 0, 0, 0, (1 << 26) - 1));
    send(mk(mse_pkg::ACT_JAL, 0, 0, 0, 0, 0));
    send(mk(mse_pkg::ACT_JR, 6, 0, 0, 0));                  // PC to all ones
    send(mk(mse_pkg::ACT_UNK, 0, 0, 0, 0));
  endtask

  // Random mix: window access sequences, branches, jumps, shifts, ALU ops
  // and a share of fully random noise.
  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned accesses;
    int          base;
    int          other;
    int          amount;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        // point a base register at the window, then load and store through it
        base  = rand_reg();
        other = rand_reg();
        send(mk(mse_pkg::ACT_SUB, base, other, other, 0));
        send(mk(mse_pkg::ACT_ADDI, base, base, 0, 16'h2000));
        send(mk(mse_pkg::ACT_SLL, base, base, 0, 16));
        sent += 3;
        if ($urandom_range(99) < 15) begin
          send(mk(mse_pkg::ACT_ADDI, base, base, 0, int'($urandom_range(3, 1))));
          sent++;
        end
        accesses = $urandom_range(4, 1);
        repeat (accesses) begin
          send(mk($urandom_range(1) ? mse_pkg::ACT_SW : mse_pkg::ACT_LW, rand_reg(),
                  base, rand_reg(), mem_offset(), rand_tgt()));
          sent++;
        end
      end else if (pick < 37) begin
        // compare a register with itself often enough to see both outcomes
        other = rand_reg();
        send(mk($urandom_range(1) ? mse_pkg::ACT_BNE : mse_pkg::ACT_BEQ, other,
                $urandom_range(1) ? other : rand_reg(), rand_reg(), rand_imm(),
                rand_tgt()));
        sent++;
      end else if (pick < 47) begin
        send(mk(mse_pkg::action_t'($urandom_range(int'(mse_pkg::ACT_JR),
                                                  int'(mse_pkg::ACT_J))),
                rand_reg(), rand_reg(), rand_reg(), rand_imm(), rand_tgt()));
        sent++;
      end else if (pick < 60) begin
        case ($urandom_range(2))
          0:       amount = int'($urandom_range(40));
          1:       amount = -int'($urandom_range(32768, 1));
          default: amount = rand_imm();
        endcase
        send(mk($urandom_range(1) ? mse_pkg::ACT_SRL : mse_pkg::ACT_SLL, rand_reg(),
                rand_reg(), rand_reg(), amount, rand_tgt()));
        sent++;
      end else if (pick < 90) begin
        send(mk(mse_pkg::action_t'($urandom_range(int'(mse_pkg::ACT_ADDI))),
                rand_reg(), rand_reg(), rand_reg(), rand_imm(), rand_tgt()));
        sent++;
      end else begin
        send(mk(mse_pkg::action_t'($urandom_range(int'(mse_pkg::ACT_UNK))),
                rand_reg(), rand_reg(), rand_reg(), rand_imm(), rand_tgt()));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst         <= 1'b1;
    cfg_wen     <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    action      <= '0;
    first_reg   <= '0;
    second_reg  <= '0;
    third_reg   <= '0;
    immediate   <= '0;
    jump_target <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed cases from the reset start PC
    run_directed();
    drain();

    // each phase starts idle: drain, reprogram start_pc, then run
    write_start_pc(32'h0000_0000);
    run_random(BURST_ITEMS);
    drain();

    // top of the address space, with both sides running flat out
    steady = 1'b1;
    write_start_pc(32'hFFFF_FFFC);
    run_random(BURST_ITEMS);
    drain();
    steady = 1'b0;

    write_start_pc(32'hFFFF_FFFF);
    run_random(BURST_ITEMS);
    drain();

    write_start_pc($urandom());
    run_random(BURST_ITEMS);
    drain();

    repeat (4) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
